// ===== hw/rtl/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types, constants and helpers of the bitmap first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

   // sizing (WORD_BITS is a power of two)
   localparam int CAPACITY    = 65536;
   localparam int WORD_BITS   = 64;
   localparam int INDEX_LIMIT = 65536;
   localparam int EFF_LIMIT   = (CAPACITY < INDEX_LIMIT) ? CAPACITY : INDEX_LIMIT;
   localparam int WORD_SHIFT  = $clog2(WORD_BITS);
   localparam int MAP_WORDS   = (EFF_LIMIT + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W       = WORD_SHIFT;
   localparam int IDX_W       = 16;
   localparam int CNT_W       = 17;
   localparam int CSR_IDX_W   = 1;

   // operations
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_TEST  = 2'd2;

   // result status
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_FULL         = 2'd1;
   localparam logic [1:0] ST_RANGE        = 2'd2;
   localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_ENTRIES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_INDEX   = 1'd1;

   // register reset values
   localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd65536;
   localparam logic             FIRST_RESET = 1'b0;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [IDX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] granted_index;
      logic             bit_value;
      logic [CNT_W-1:0] free_count;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_NONE   = 2'd0,
      RD_FIRST  = 2'd1,
      RD_NEXT   = 2'd2,
      RD_LOOKUP = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      FIN_NONE   = 2'd0,
      FIN_EARLY  = 2'd1,
      FIN_SCAN   = 2'd2,
      FIN_LOOKUP = 2'd3
   } fin_type;

   typedef struct packed {
      logic       clr_wr;
      logic       accept;
      rd_sel_type rd_sel;
      fin_type    fin;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic early_exit;
      logic is_alloc;
      logic scan_done;
   } dp_status_type;

   // total limited to what the store and the index width can hold
   function automatic logic [CNT_W-1:0] eff_total_f(input logic [CNT_W-1:0] t);
      logic [CNT_W-1:0] lim;
      lim = CNT_W'(EFF_LIMIT);
      return (t > lim) ? lim : t;
   endfunction

   // free blocks after a register write
   function automatic logic [CNT_W-1:0] reload_f(input logic [CNT_W-1:0] t,
                                                 input logic first);
      logic [CNT_W-1:0] e;
      logic [CNT_W-1:0] f;
      e = eff_total_f(t);
      f = {{(CNT_W-1){1'b0}}, first};
      return (e > f) ? e - f : '0;
   endfunction

endpackage

// ===== hw/rtl/bffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer: clearing pass, command decode, word scan and result strobe.
// ----------------------------------------------------------------------------
module bffa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   input  bffa_pkg::dp_status_type st,
   output bffa_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_CHECK  = 5'b00100,
      S_SCAN   = 5'b01000,
      S_MODIFY = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd.clr_wr = 1'b0;
      cmd.accept = 1'b0;
      cmd.rd_sel = bffa_pkg::RD_NONE;
      cmd.fin    = bffa_pkg::FIN_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.early_exit) begin
               cmd.fin  = bffa_pkg::FIN_EARLY;
               state_in = S_IDLE;
            end else if (st.is_alloc) begin
               cmd.rd_sel = bffa_pkg::RD_FIRST;
               state_in   = S_SCAN;
            end else begin
               cmd.rd_sel = bffa_pkg::RD_LOOKUP;
               state_in   = S_MODIFY;
            end
         end
         S_SCAN: begin
            if (st.scan_done) begin
               cmd.fin  = bffa_pkg::FIN_SCAN;
               state_in = S_IDLE;
            end else begin
               cmd.rd_sel = bffa_pkg::RD_NEXT;
            end
         end
         S_MODIFY: begin
            cmd.fin  = bffa_pkg::FIN_LOOKUP;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = (cmd.fin != bffa_pkg::FIN_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/bffa_datapath.sv =====
// ----------------------------------------------------------------------------
// bffa_datapath
// Used-mark store, free counter, registers, word evaluation and result word.
// ----------------------------------------------------------------------------
module bffa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  bffa_pkg::req_type                   req_data,
   output bffa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr,
   input  logic [bffa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bffa_pkg::CNT_W-1:0]          csr_data,
   input  bffa_pkg::ctrl_cmd_type              cmd,
   output bffa_pkg::dp_status_type             st
);

   localparam int WB = bffa_pkg::WORD_BITS;
   localparam int AW = bffa_pkg::WADDR_W;
   localparam int CW = bffa_pkg::CNT_W;
   localparam int IW = bffa_pkg::IDX_W;
   localparam int BW = bffa_pkg::BIT_W;

   // store
   logic [WB-1:0] mem [bffa_pkg::MAP_WORDS];
   logic [WB-1:0] rd_data_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [WB-1:0] wr_data;

   // registers
   logic [CW-1:0] total_ff, total_in;
   logic          first_ff, first_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic [1:0]    op_ff;
   logic [IW-1:0] idx_ff;
   bffa_pkg::rsp_type rsp_ff, rsp_in;

   // evaluation
   logic [CW-1:0] eff_total;
   logic          in_range;
   logic          is_alloc;
   logic [AW-1:0] look_addr;
   logic [BW-1:0] look_off;
   logic          look_bit;
   logic [CW-1:0] scan_w;
   logic [CW-1:0] full_words;
   logic [CW-1:0] last_word;
   logic [BW-1:0] rem;
   logic [WB-1:0] mask;
   logic [WB-1:0] avail;
   logic [WB-1:0] onehot;
   logic [BW-1:0] bit_idx;
   logic          found;
   logic          scan_last;
   logic [IW-1:0] grant_pos;

   assign eff_total = bffa_pkg::eff_total_f(total_ff);
   assign in_range  = ({1'b0, idx_ff} < eff_total);
   assign is_alloc  = (op_ff == bffa_pkg::OP_ALLOC);
   assign look_addr = AW'(idx_ff >> bffa_pkg::WORD_SHIFT);
   assign look_off  = idx_ff[BW-1:0];
   assign look_bit  = rd_data_ff[look_off];

   // word mask: blocks below the total and at or above the first index
   assign scan_w     = CW'(scan_addr_ff);
   assign full_words = eff_total >> bffa_pkg::WORD_SHIFT;
   assign rem        = eff_total[BW-1:0];
   assign last_word  = (eff_total - 1'b1) >> bffa_pkg::WORD_SHIFT;

   always_comb begin
      if (scan_w < full_words) begin
         mask = '1;
      end else if (scan_w == full_words) begin
         mask = ~({WB{1'b1}} << rem);
      end else begin
         mask = '0;
      end
      if ((scan_addr_ff == '0) && first_ff) begin
         mask[0] = 1'b0;
      end
   end

   assign avail     = ~rd_data_ff & mask;
   assign found     = |avail;
   assign onehot    = avail & (~avail + 1'b1);
   assign scan_last = (scan_w == last_word);

   always_comb begin
      bit_idx = '0;
      for (int b = 0; b < WB; b++) begin
         if (onehot[b]) begin
            bit_idx = bit_idx | BW'(b);
         end
      end
   end

   assign grant_pos = IW'({scan_addr_ff, bit_idx});

   assign st.clr_last   = (clr_addr_ff == AW'(bffa_pkg::MAP_WORDS - 1));
   assign st.is_alloc   = is_alloc;
   assign st.early_exit = is_alloc ? (eff_total == '0) : !in_range;
   assign st.scan_done  = found || scan_last;

   // read port
   always_comb begin
      rd_en        = 1'b1;
      rd_addr      = '0;
      scan_addr_in = scan_addr_ff;
      case (cmd.rd_sel)
         bffa_pkg::RD_FIRST: begin
            scan_addr_in = '0;
         end
         bffa_pkg::RD_NEXT: begin
            rd_addr      = scan_addr_ff + 1'b1;
            scan_addr_in = scan_addr_ff + 1'b1;
         end
         bffa_pkg::RD_LOOKUP: begin
            rd_addr = look_addr;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // write port, counter and result word
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = clr_addr_ff;
      wr_data     = '0;
      clr_addr_in = clr_addr_ff;
      cnt_in      = cnt_ff;
      rsp_in      = rsp_ff;
      total_in    = total_ff;
      first_in    = first_ff;

      if (cmd.clr_wr) begin
         wr_en       = 1'b1;
         clr_addr_in = clr_addr_ff + 1'b1;
      end

      rsp_in.granted_index = idx_ff;
      rsp_in.bit_value     = 1'b0;
      rsp_in.status        = bffa_pkg::ST_OK;
      case (cmd.fin)
         bffa_pkg::FIN_EARLY: begin
            rsp_in.status = is_alloc ? bffa_pkg::ST_FULL : bffa_pkg::ST_RANGE;
         end
         bffa_pkg::FIN_SCAN: begin
            if (found) begin
               wr_en                = 1'b1;
               wr_addr              = scan_addr_ff;
               wr_data              = rd_data_ff | onehot;
               rsp_in.granted_index = grant_pos;
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end else begin
               rsp_in.status = bffa_pkg::ST_FULL;
            end
         end
         bffa_pkg::FIN_LOOKUP: begin
            rsp_in.bit_value = look_bit;
            if (op_ff == bffa_pkg::OP_FREE) begin
               if (look_bit) begin
                  wr_en   = 1'b1;
                  wr_addr = look_addr;
                  wr_data = rd_data_ff & ~({{(WB-1){1'b0}}, 1'b1} << look_off);
                  if (cnt_ff < eff_total) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  rsp_in.status = bffa_pkg::ST_ALREADY_FREE;
               end
            end
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase

      if (csr_wr) begin
         case (csr_index)
            bffa_pkg::CSR_TOTAL_ENTRIES: begin
               total_in = csr_data;
               cnt_in   = bffa_pkg::reload_f(csr_data, first_ff);
            end
            bffa_pkg::CSR_FIRST_INDEX: begin
               first_in = csr_data[0];
               cnt_in   = bffa_pkg::reload_f(total_ff, csr_data[0]);
            end
            default: begin
               total_in = total_ff;
            end
         endcase
      end

      rsp_in.free_count = (cmd.fin != bffa_pkg::FIN_NONE) ? cnt_in : rsp_ff.free_count;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= bffa_pkg::TOTAL_RESET;
         first_ff    <= bffa_pkg::FIRST_RESET;
         cnt_ff      <= bffa_pkg::reload_f(bffa_pkg::TOTAL_RESET, bffa_pkg::FIRST_RESET);
         clr_addr_ff <= '0;
      end else begin
         total_ff    <= total_in;
         first_ff    <= first_in;
         cnt_ff      <= cnt_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      rsp_ff       <= rsp_in;
      if (cmd.accept) begin
         op_ff  <= req_data.opcode;
         idx_ff <= req_data.block_index;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/bitmap_first_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_unit
// Block allocator over a bitmap of used marks with a free-block counter.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// rsp_data for one cycle with rsp_valid and must be captured then. After reset
// the unit clears its bitmap one memory word per cycle, all MAP_WORDS words
// (1024 as built), with busy high; register writes are taken during that time.
// Free and test go through the check and modify states before their result
// is registered; a range error or an allocate with no blocks configured ends
// in the check state. Allocate reads one bitmap word per cycle from the start
// of the map until the first word holding a free block or the last word in
// range. busy falls in the cycle the result is shown, so the next word can be
// taken then. The csr port is always ready.
module bitmap_first_fit_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  bffa_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output bffa_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bffa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bffa_pkg::CNT_W-1:0]     csr_data
);

   bffa_pkg::ctrl_cmd_type  cmd;
   bffa_pkg::dp_status_type st;

   assign csr_ready = 1'b1;

   bffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .st        (st),
      .cmd       (cmd)
   );

   bffa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .st        (st)
   );

endmodule

// ===== hw/rtl/bffa_checker.sv =====
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bffa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input bffa_pkg::req_type              req_data,
   input logic                           rsp_valid,
   input bffa_pkg::rsp_type              rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [bffa_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [bffa_pkg::CNT_W-1:0]     csr_data
);

   // accepted word is never answered in the next cycle and keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted word not held busy");

   // a result frees the unit in the same cycle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // results never come in consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // failure statuses carry no used mark and the count stays in range
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.free_count <= bffa_pkg::CNT_W'(bffa_pkg::EFF_LIMIT)) &&
                     ((rsp_data.status == bffa_pkg::ST_OK) ||
                      (rsp_data.bit_value == 1'b0))))
      else $error("inconsistent result fields");

endmodule

bind bitmap_first_fit_allocator_unit bffa_checker u_bffa_checker (.*);
